[design/bmv_pkg.sv]
`default_nettype none

package bmv_pkg;

    localparam int DataWidth   = 8;
    localparam int CfgWidth    = 16;
    localparam int OutTdataW   = 160;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_LENGTH  = 4'd1;
    localparam logic [3:0] ST_MARKER      = 4'd2;
    localparam logic [3:0] ST_VERSION     = 4'd3;
    localparam logic [3:0] ST_HOLD        = 4'd4;
    localparam logic [3:0] ST_PARAMS      = 4'd5;
    localparam logic [3:0] ST_PARAM_TYPE  = 4'd6;
    localparam logic [3:0] ST_NOTIF_CODE  = 4'd7;
    localparam logic [3:0] ST_TYPE        = 4'd8;
    localparam logic [3:0] ST_REFRESH_LEN = 4'd9;
    localparam logic [3:0] ST_NO_CAPS     = 4'd10;

    localparam logic [7:0] MSG_OPEN      = 8'd1;
    localparam logic [7:0] MSG_UPDATE    = 8'd2;
    localparam logic [7:0] MSG_NOTIF     = 8'd3;
    localparam logic [7:0] MSG_KEEPALIVE = 8'd4;
    localparam logic [7:0] MSG_REFRESH   = 8'd5;

    localparam logic [7:0] PARAM_CAPS    = 8'd2;
    localparam logic [7:0] BGP_VERSION   = 8'd4;

    localparam logic CFG_MAX_LEN   = 1'b0;
    localparam logic CFG_UPDATE_EN = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } beat_t;

    // first member sits in the highest bits
    typedef struct packed {
        logic [7:0]  refresh_subtype;
        logic [7:0]  family_safi;
        logic [15:0] family_afi;
        logic [15:0] notif_data_count;
        logic [7:0]  error_subcode;
        logic [7:0]  error_code;
        logic [31:0] router_id;
        logic [15:0] hold_seconds;
        logic [15:0] peer_asn;
        logic [15:0] message_length;
        logic [7:0]  message_type;
        logic [3:0]  status;
    } result_t;

endpackage

`default_nettype wire

[design/bmv_in_stage.sv]
`default_nettype none

module bmv_in_stage (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire  [7:0]         s_tdata,
    input  wire                s_tlast,
    input  wire                out_space,
    output logic               step,
    output bmv_pkg::beat_t     beat
);

    logic           valid_reg;
    logic           valid_next;
    bmv_pkg::beat_t beat_reg;

    // a last byte waits until the result register can take its result
    assign step     = valid_reg && (!beat_reg.last_byte || out_space);
    assign s_tready = !valid_reg || step;
    assign beat     = beat_reg;

    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            beat_reg.data_byte <= s_tdata;
            beat_reg.last_byte <= s_tlast;
        end
    end

endmodule

`default_nettype wire

[design/bmv_core.sv]
`default_nettype none

module bmv_core (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                step,
    input  bmv_pkg::beat_t     beat,
    input  wire                cfg_we,
    input  wire                cfg_addr,
    input  wire  [15:0]        cfg_data,
    output logic               res_valid,
    output bmv_pkg::result_t   result
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_VALUE
    } tlv_phase_t;

    logic [15:0] max_len_reg;
    logic        update_en_reg;

    logic [15:0] byte_index_reg, byte_index_next;
    logic [15:0] header_length_reg, header_length_next;
    logic [7:0]  header_type_reg, header_type_next;
    logic        done_flag_reg, done_flag_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic [7:0]  params_remaining_reg, params_remaining_next;
    tlv_phase_t  tlv_phase_reg, tlv_phase_next;
    logic [7:0]  tlv_remaining_reg, tlv_remaining_next;
    logic [3:0]  hdr_err_reg, hdr_err_next;
    logic [3:0]  body_err_reg, body_err_next;
    logic [7:0]  ptype_reg, ptype_next;
    logic [15:0] asn_reg, asn_next;
    logic [15:0] hold_reg, hold_next;
    logic [15:0] afi_reg, afi_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  sub_reg, sub_next;
    logic [7:0]  safi_reg, safi_next;
    logic [7:0]  rsub_reg, rsub_next;

    function automatic logic notif_ok(input logic [7:0] c, input logic [7:0] s);
        logic ok;
        begin
            unique case (c)
                8'd1:       ok = (s <= 8'd3);
                8'd2:       ok = (s <= 8'd7);
                8'd3:       ok = (s <= 8'd11);
                8'd4, 8'd5: ok = 1'b1;
                8'd6:       ok = (s <= 8'd8);
                8'd7:       ok = (s == 8'd0);
                default:    ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

    always_comb
    begin
        logic [15:0] idx;
        logic [7:0]  b;
        logic [15:0] off;
        logic [15:0] room;
        logic [15:0] hold_word;
        logic        chk;

        idx       = byte_index_reg;
        b         = beat.data_byte;
        off       = idx - 16'd19;
        room      = (header_length_reg >= 16'd29) ? (header_length_reg - 16'd29) : 16'd0;
        hold_word = {hold_reg[7:0], b};
        chk       = (hdr_err_reg == bmv_pkg::ST_OK) && (body_err_reg == bmv_pkg::ST_OK);

        byte_index_next       = byte_index_reg;
        header_length_next    = header_length_reg;
        header_type_next      = header_type_reg;
        done_flag_next        = done_flag_reg;
        field_shift_next      = field_shift_reg;
        params_remaining_next = params_remaining_reg;
        tlv_phase_next        = tlv_phase_reg;
        tlv_remaining_next    = tlv_remaining_reg;
        hdr_err_next          = hdr_err_reg;
        body_err_next         = body_err_reg;
        ptype_next            = ptype_reg;
        asn_next              = asn_reg;
        hold_next             = hold_reg;
        afi_next              = afi_reg;
        code_next             = code_reg;
        sub_next              = sub_reg;
        safi_next             = safi_reg;
        rsub_next             = rsub_reg;
        res_valid             = 1'b0;
        result                = '0;

        if (step)
        begin
            if (idx < 16'd16)
            begin
                if (b != 8'hFF && hdr_err_reg == bmv_pkg::ST_OK)
                begin
                    hdr_err_next = bmv_pkg::ST_MARKER;
                end
            end
            else if (idx == 16'd16)
            begin
                header_length_next = {b, 8'h00};
            end
            else if (idx == 16'd17)
            begin
                header_length_next = header_length_reg | {8'h00, b};
            end
            else if (idx == 16'd18)
            begin
                header_type_next = b;
                done_flag_next   = 1'b1;
                if (hdr_err_reg == bmv_pkg::ST_OK)
                begin
                    priority if (header_length_reg < 16'd19 || header_length_reg > max_len_reg)
                    begin
                        hdr_err_next = bmv_pkg::ST_BAD_LENGTH;
                    end
                    else if (b == 8'd0 || b > bmv_pkg::MSG_REFRESH)
                    begin
                        hdr_err_next = bmv_pkg::ST_TYPE;
                    end
                    else if (b == bmv_pkg::MSG_UPDATE && !update_en_reg)
                    begin
                        hdr_err_next = bmv_pkg::ST_NO_CAPS;
                    end
                    else if ((b == bmv_pkg::MSG_OPEN && header_length_reg < 16'd29) ||
                             (b == bmv_pkg::MSG_UPDATE && header_length_reg < 16'd23) ||
                             (b == bmv_pkg::MSG_NOTIF && header_length_reg < 16'd21) ||
                             (b == bmv_pkg::MSG_KEEPALIVE && header_length_reg != 16'd19) ||
                             (b == bmv_pkg::MSG_REFRESH && header_length_reg < 16'd23))
                    begin
                        body_err_next = bmv_pkg::ST_BAD_LENGTH;
                    end
                    else
                    begin
                        body_err_next = body_err_reg;
                    end
                end
            end
            else if (done_flag_reg && idx < header_length_reg)
            begin
                if (header_type_reg == bmv_pkg::MSG_OPEN)
                begin
                    if (off == 16'd0)
                    begin
                        if (chk && b != bmv_pkg::BGP_VERSION)
                        begin
                            body_err_next = bmv_pkg::ST_VERSION;
                        end
                    end
                    else if (off <= 16'd2)
                    begin
                        asn_next = {asn_reg[7:0], b};
                    end
                    else if (off <= 16'd4)
                    begin
                        hold_next = hold_word;
                        if (off == 16'd4 && chk && hold_word != 16'd0 && hold_word < 16'd3)
                        begin
                            body_err_next = bmv_pkg::ST_HOLD;
                        end
                    end
                    else if (off <= 16'd8)
                    begin
                        field_shift_next = {field_shift_reg[23:0], b};
                    end
                    else if (off == 16'd9)
                    begin
                        if (chk)
                        begin
                            if ({8'h00, b} > room)
                            begin
                                body_err_next = bmv_pkg::ST_PARAMS;
                            end
                            else
                            begin
                                params_remaining_next = b;
                                tlv_phase_next        = PH_TYPE;
                            end
                        end
                    end
                    else if (chk && params_remaining_reg != 8'd0)
                    begin
                        params_remaining_next = params_remaining_reg - 8'd1;
                        unique case (tlv_phase_reg)
                            PH_TYPE:
                            begin
                                ptype_next = b;
                                if (params_remaining_next == 8'd0)
                                begin
                                    body_err_next = bmv_pkg::ST_PARAMS;
                                end
                                else
                                begin
                                    tlv_phase_next = PH_LEN;
                                end
                            end
                            PH_LEN:
                            begin
                                priority if (b > params_remaining_next)
                                begin
                                    body_err_next = bmv_pkg::ST_PARAMS;
                                end
                                else if (ptype_reg != bmv_pkg::PARAM_CAPS)
                                begin
                                    body_err_next = bmv_pkg::ST_PARAM_TYPE;
                                end
                                else if (b != 8'd0)
                                begin
                                    tlv_remaining_next = b;
                                    tlv_phase_next     = PH_VALUE;
                                end
                                else
                                begin
                                    tlv_phase_next = PH_TYPE;
                                end
                            end
                            default:
                            begin
                                if (tlv_remaining_reg != 8'd0)
                                begin
                                    tlv_remaining_next = tlv_remaining_reg - 8'd1;
                                end
                                if (tlv_remaining_next == 8'd0)
                                begin
                                    tlv_phase_next = PH_TYPE;
                                end
                            end
                        endcase
                    end
                end
                else if (header_type_reg == bmv_pkg::MSG_NOTIF)
                begin
                    if (off == 16'd0)
                    begin
                        code_next = b;
                    end
                    else if (off == 16'd1)
                    begin
                        sub_next = b;
                        if (chk && !notif_ok(code_reg, b))
                        begin
                            body_err_next = bmv_pkg::ST_NOTIF_CODE;
                        end
                    end
                end
                else if (header_type_reg == bmv_pkg::MSG_REFRESH)
                begin
                    priority if (off <= 16'd1)
                    begin
                        afi_next = {afi_reg[7:0], b};
                    end
                    else if (off == 16'd2)
                    begin
                        rsub_next = b;
                        if (chk && header_length_reg != 16'd23 && (b == 8'd1 || b == 8'd2))
                        begin
                            body_err_next = bmv_pkg::ST_REFRESH_LEN;
                        end
                    end
                    else if (off == 16'd3)
                    begin
                        safi_next = b;
                    end
                    else
                    begin
                        safi_next = safi_reg;
                    end
                end
            end

            if (byte_index_reg != 16'hFFFF)
            begin
                byte_index_next = byte_index_reg + 16'd1;
            end

            if (beat.last_byte)
            begin
                res_valid = 1'b1;
                priority if (byte_index_next < 16'd19)
                begin
                    result.status = bmv_pkg::ST_BAD_LENGTH;
                end
                else if (hdr_err_next != bmv_pkg::ST_OK)
                begin
                    result.status = hdr_err_next;
                end
                else if (byte_index_next < header_length_next)
                begin
                    result.status = bmv_pkg::ST_BAD_LENGTH;
                end
                else
                begin
                    result.status = body_err_next;
                end
                result.message_type     = header_type_next;
                result.message_length   = header_length_next;
                result.peer_asn         = asn_next;
                result.hold_seconds     = hold_next;
                result.router_id        = field_shift_next;
                result.error_code       = code_next;
                result.error_subcode    = sub_next;
                result.notif_data_count =
                    (header_type_next == bmv_pkg::MSG_NOTIF && header_length_next >= 16'd21)
                    ? (header_length_next - 16'd21) : 16'd0;
                result.family_afi       = afi_next;
                result.family_safi      = safi_next;
                result.refresh_subtype  = rsub_next;

                // start over for the next buffer
                byte_index_next       = '0;
                header_length_next    = '0;
                header_type_next      = '0;
                done_flag_next        = 1'b0;
                field_shift_next      = '0;
                params_remaining_next = '0;
                tlv_phase_next        = PH_TYPE;
                tlv_remaining_next    = '0;
                hdr_err_next          = bmv_pkg::ST_OK;
                body_err_next         = bmv_pkg::ST_OK;
                ptype_next            = '0;
                asn_next              = '0;
                hold_next             = '0;
                afi_next              = '0;
                code_next             = '0;
                sub_next              = '0;
                safi_next             = '0;
                rsub_next             = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= 16'd4096;
            update_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bmv_pkg::CFG_MAX_LEN:   max_len_reg   <= cfg_data;
                bmv_pkg::CFG_UPDATE_EN: update_en_reg <= cfg_data[0];
                default:                max_len_reg   <= max_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg       <= '0;
            header_length_reg    <= '0;
            header_type_reg      <= '0;
            done_flag_reg        <= 1'b0;
            field_shift_reg      <= '0;
            params_remaining_reg <= '0;
            tlv_phase_reg        <= PH_TYPE;
            tlv_remaining_reg    <= '0;
            hdr_err_reg          <= bmv_pkg::ST_OK;
            body_err_reg         <= bmv_pkg::ST_OK;
            ptype_reg            <= '0;
            asn_reg              <= '0;
            hold_reg             <= '0;
            afi_reg              <= '0;
            code_reg             <= '0;
            sub_reg              <= '0;
            safi_reg             <= '0;
            rsub_reg             <= '0;
        end
        else
        begin
            byte_index_reg       <= byte_index_next;
            header_length_reg    <= header_length_next;
            header_type_reg      <= header_type_next;
            done_flag_reg        <= done_flag_next;
            field_shift_reg      <= field_shift_next;
            params_remaining_reg <= params_remaining_next;
            tlv_phase_reg        <= tlv_phase_next;
            tlv_remaining_reg    <= tlv_remaining_next;
            hdr_err_reg          <= hdr_err_next;
            body_err_reg         <= body_err_next;
            ptype_reg            <= ptype_next;
            asn_reg              <= asn_next;
            hold_reg             <= hold_next;
            afi_reg              <= afi_next;
            code_reg             <= code_next;
            sub_reg              <= sub_next;
            safi_reg             <= safi_next;
            rsub_reg             <= rsub_next;
        end
    end

    a_hdr_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_err_reg != bmv_pkg::ST_OK && !res_valid) |=> hdr_err_reg == $past(hdr_err_reg))
        else $error("header error changed within a message");

    a_done_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        done_flag_reg |-> byte_index_reg >= 16'd19)
        else $error("header marked done too early");

    a_params_only_open: assert property (@(posedge clk) disable iff (!rst_n)
        params_remaining_reg != 8'd0 |-> header_type_reg == bmv_pkg::MSG_OPEN)
        else $error("parameter count outside an OPEN message");

    a_value_phase_count: assert property (@(posedge clk) disable iff (!rst_n)
        tlv_phase_reg == PH_VALUE |-> tlv_remaining_reg != 8'd0)
        else $error("value phase with no bytes left");

endmodule

`default_nettype wire

[design/bmv_out_reg.sv]
`default_nettype none

module bmv_out_reg (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                res_valid,
    input  bmv_pkg::result_t   result,
    output logic               out_space,
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [159:0]       m_tdata
);

    localparam int PadW = bmv_pkg::OutTdataW - $bits(bmv_pkg::result_t);

    logic             valid_reg;
    logic             valid_next;
    bmv_pkg::result_t data_reg;

    assign out_space = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {{PadW{1'b0}}, data_reg};

    always_comb
    begin
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

[design/bgp_message_validator.sv]
// channel   | direction | beat
// s_axis    | in        | tdata[7:0] data_byte, tlast last_byte
// m_axis    | out       | tdata status .. refresh_subtype, one beat per buffer
// cfg       | in        | cfg_addr 0 max_message_length, 1 update_enabled
//
// One byte per cycle unless stalled as below; the byte counter and field compares
// update in one step. m_tvalid comes from the result register, fed via the input register.
// Reset clears the parser state and loads max length 4096 and update enable 1.
// A held result stalls the input only when the next last byte reaches the parser.
`default_nettype none

module bgp_message_validator (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,   // [7:0] data_byte
    input  wire          s_tlast,
    output logic         m_tvalid,
    input  wire          m_tready,
    // [3:0] status, [11:4] message_type, [27:12] message_length, [43:28] peer_asn,
    // [59:44] hold_seconds, [91:60] router_id, [99:92] error_code,
    // [107:100] error_subcode, [123:108] notif_data_count, [139:124] family_afi,
    // [147:140] family_safi, [155:148] refresh_subtype, [159:156] zero
    output logic [159:0] m_tdata,
    input  wire          cfg_we,
    input  wire          cfg_addr,
    input  wire  [15:0]  cfg_data
);

    logic             step;
    logic             out_space;
    logic             res_valid;
    bmv_pkg::beat_t   beat;
    bmv_pkg::result_t result;

    bmv_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .out_space (out_space),
        .step      (step),
        .beat      (beat)
    );

    bmv_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .beat      (beat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .result    (result)
    );

    bmv_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .result    (result),
        .out_space (out_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[sim/bgp_result_checker.sv]
module bgp_result_checker (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [7:0]   s_tdata,   // [7:0] data_byte
    input  wire          s_tlast,
    input  wire          m_tvalid,
    input  wire          m_tready,
    // [3:0] status .. [155:148] refresh_subtype, [159:156] zero
    input  wire  [159:0] m_tdata,
    input  wire          cfg_we,
    input  wire          cfg_addr,
    input  wire  [15:0]  cfg_data,
    output int           mismatches,
    output int           verdicts_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {TLV_TYPE, TLV_LEN, TLV_VALUE} tlv_state_t;

    localparam logic [7:0] NOTIF_HEADER  = 8'd1;
    localparam logic [7:0] NOTIF_OPEN    = 8'd2;
    localparam logic [7:0] NOTIF_UPDATE  = 8'd3;
    localparam logic [7:0] NOTIF_HOLD    = 8'd4;
    localparam logic [7:0] NOTIF_FSM     = 8'd5;
    localparam logic [7:0] NOTIF_CEASE   = 8'd6;
    localparam logic [7:0] NOTIF_REFRESH = 8'd7;

    logic [15:0] max_len;
    logic        upd_en;

    logic [15:0] byte_count;
    logic [15:0] hdr_len;
    logic [7:0]  hdr_type;
    logic        hdr_seen;
    logic [31:0] rid;
    logic [7:0]  param_left;
    tlv_state_t  tlv_state;
    logic [7:0]  value_left;
    logic [3:0]  hdr_fault;
    logic [3:0]  body_fault;
    logic [7:0]  param_kind;
    logic [15:0] asn, hold, afi;
    logic [7:0]  code, sub, safi, rsub;

    bmv_pkg::result_t awaited_verdicts[$];

    function automatic void clear_message();
        byte_count = '0;
        hdr_len    = '0;
        hdr_type   = '0;
        hdr_seen   = 1'b0;
        rid        = '0;
        param_left = '0;
        tlv_state  = TLV_TYPE;
        value_left = '0;
        hdr_fault  = bmv_pkg::ST_OK;
        body_fault = bmv_pkg::ST_OK;
        param_kind = '0;
        asn  = '0;
        hold = '0;
        afi  = '0;
        code = '0;
        sub  = '0;
        safi = '0;
        rsub = '0;
    endfunction

    function automatic void flag_body(logic [3:0] st);
        if (hdr_fault == bmv_pkg::ST_OK && body_fault == bmv_pkg::ST_OK)
            body_fault = st;
    endfunction

    function automatic bit notif_pair_ok(logic [7:0] c, logic [7:0] s);
        case (c)
            NOTIF_HEADER:         return s <= 8'd3;
            NOTIF_OPEN:           return s <= 8'd7;
            NOTIF_UPDATE:         return s <= 8'd11;
            NOTIF_HOLD, NOTIF_FSM: return 1'b1;
            NOTIF_CEASE:          return s <= 8'd8;
            NOTIF_REFRESH:        return s == 8'd0;
            default:              return 1'b0;
        endcase
    endfunction

    function automatic void param_byte(logic [7:0] b);
        if (param_left == 0)
            return;
        case (tlv_state)
            TLV_TYPE:
            begin
                param_kind = b;
                param_left--;
                if (param_left == 0)
                    flag_body(bmv_pkg::ST_PARAMS);
                else
                    tlv_state = TLV_LEN;
            end
            TLV_LEN:
            begin
                param_left--;
                if (b > param_left)
                    flag_body(bmv_pkg::ST_PARAMS);
                else if (param_kind != bmv_pkg::PARAM_CAPS)
                    flag_body(bmv_pkg::ST_PARAM_TYPE);
                else if (b != 0)
                begin
                    value_left = b;
                    tlv_state  = TLV_VALUE;
                end
                else
                    tlv_state = TLV_TYPE;
            end
            default:
            begin
                param_left--;
                if (value_left > 0)
                    value_left--;
                if (value_left == 0)
                    tlv_state = TLV_TYPE;
            end
        endcase
    endfunction

    function automatic void body_byte(logic [15:0] off, logic [7:0] b);
        bit          clean;
        logic [15:0] room;
        clean = hdr_fault == bmv_pkg::ST_OK && body_fault == bmv_pkg::ST_OK;
        case (hdr_type)
            bmv_pkg::MSG_OPEN:
            begin
                if (off == 0)
                begin
                    if (clean && b != bmv_pkg::BGP_VERSION)
                        flag_body(bmv_pkg::ST_VERSION);
                end
                else if (off <= 2)
                    asn = {asn[7:0], b};
                else if (off <= 4)
                begin
                    hold = {hold[7:0], b};
                    if (off == 4 && clean && hold != 0 && hold < 3)
                        flag_body(bmv_pkg::ST_HOLD);
                end
                else if (off <= 8)
                    rid = {rid[23:0], b};
                else if (off == 9)
                begin
                    if (clean)
                    begin
                        room = (hdr_len >= 29) ? hdr_len - 16'd29 : 16'd0;
                        if (16'(b) > room)
                            flag_body(bmv_pkg::ST_PARAMS);
                        else
                        begin
                            param_left = b;
                            tlv_state  = TLV_TYPE;
                        end
                    end
                end
                else if (clean)
                    param_byte(b);
            end
            bmv_pkg::MSG_NOTIF:
            begin
                if (off == 0)
                    code = b;
                else if (off == 1)
                begin
                    sub = b;
                    if (clean && !notif_pair_ok(code, sub))
                        flag_body(bmv_pkg::ST_NOTIF_CODE);
                end
            end
            bmv_pkg::MSG_REFRESH:
            begin
                if (off <= 1)
                    afi = {afi[7:0], b};
                else if (off == 2)
                begin
                    rsub = b;
                    if (clean && hdr_len != 23 && (b == 8'd1 || b == 8'd2))
                        flag_body(bmv_pkg::ST_REFRESH_LEN);
                end
                else if (off == 3)
                    safi = b;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void close_header();
        hdr_seen = 1'b1;
        if (hdr_fault == bmv_pkg::ST_OK)
        begin
            if (hdr_len < 19 || hdr_len > max_len)
                hdr_fault = bmv_pkg::ST_BAD_LENGTH;
            else if (hdr_type < bmv_pkg::MSG_OPEN || hdr_type > bmv_pkg::MSG_REFRESH)
                hdr_fault = bmv_pkg::ST_TYPE;
            else if (hdr_type == bmv_pkg::MSG_UPDATE && !upd_en)
                hdr_fault = bmv_pkg::ST_NO_CAPS;
        end
        if (hdr_fault == bmv_pkg::ST_OK)
        begin
            if ((hdr_type == bmv_pkg::MSG_OPEN && hdr_len < 29)
                || (hdr_type == bmv_pkg::MSG_UPDATE && hdr_len < 23)
                || (hdr_type == bmv_pkg::MSG_NOTIF && hdr_len < 21)
                || (hdr_type == bmv_pkg::MSG_KEEPALIVE && hdr_len != 19)
                || (hdr_type == bmv_pkg::MSG_REFRESH && hdr_len < 23))
                body_fault = bmv_pkg::ST_BAD_LENGTH;
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        logic [15:0]      idx;
        bmv_pkg::result_t r;
        idx = byte_count;
        if (idx < 16)
        begin
            if (b != 8'hFF && hdr_fault == bmv_pkg::ST_OK)
                hdr_fault = bmv_pkg::ST_MARKER;
        end
        else if (idx == 16)
            hdr_len = {b, 8'h00};
        else if (idx == 17)
            hdr_len[7:0] = b;
        else if (idx == 18)
        begin
            hdr_type = b;
            close_header();
        end
        else if (hdr_seen && idx < hdr_len)
            body_byte(idx - 16'd19, b);
        if (byte_count != 16'hFFFF)
            byte_count++;

        if (!last)
            return;

        r = '0;
        if (byte_count < 19)
            r.status = bmv_pkg::ST_BAD_LENGTH;
        else if (hdr_fault != bmv_pkg::ST_OK)
            r.status = hdr_fault;
        else if (byte_count < hdr_len)
            r.status = bmv_pkg::ST_BAD_LENGTH;
        else
            r.status = body_fault;
        r.message_type    = hdr_type;
        r.message_length  = hdr_len;
        r.peer_asn        = asn;
        r.hold_seconds    = hold;
        r.router_id       = rid;
        r.error_code      = code;
        r.error_subcode   = sub;
        r.notif_data_count = (hdr_type == bmv_pkg::MSG_NOTIF && hdr_len >= 21) ?
                             hdr_len - 16'd21 : 16'd0;
        r.family_afi      = afi;
        r.family_safi     = safi;
        r.refresh_subtype = rsub;
        awaited_verdicts.push_back(r);
        clear_message();
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, want %0h", name, got, want));
    endtask

    task automatic check_verdict(input logic [159:0] beat);
        bmv_pkg::result_t got;
        bmv_pkg::result_t want;
        got = beat[155:0];
        if (awaited_verdicts.size() == 0)
        begin
            report_mismatch($sformatf("result beat with status %0d and no buffer open",
                                      got.status));
            return;
        end
        want = awaited_verdicts.pop_front();
        compare_field("pad bits", beat[159:156], 0);
        compare_field("status", got.status, want.status);
        compare_field("message_type", got.message_type, want.message_type);
        compare_field("message_length", got.message_length, want.message_length);
        compare_field("peer_asn", got.peer_asn, want.peer_asn);
        compare_field("hold_seconds", got.hold_seconds, want.hold_seconds);
        compare_field("router_id", got.router_id, want.router_id);
        compare_field("error_code", got.error_code, want.error_code);
        compare_field("error_subcode", got.error_subcode, want.error_subcode);
        compare_field("notif_data_count", got.notif_data_count, want.notif_data_count);
        compare_field("family_afi", got.family_afi, want.family_afi);
        compare_field("family_safi", got.family_safi, want.family_safi);
        compare_field("refresh_subtype", got.refresh_subtype, want.refresh_subtype);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len = 16'd4096;
            upd_en  = 1'b1;
            clear_message();
            awaited_verdicts.delete();
            mismatches = 0;
            verdicts_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == bmv_pkg::CFG_MAX_LEN)
                    max_len = cfg_data;
                else
                    upd_en = cfg_data[0];
            end
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_verdict(m_tdata);
            verdicts_due <= awaited_verdicts.size();
        end
    end

endmodule

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QuietLimit = 2000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] data_byte
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    // [3:0] status .. [155:148] refresh_subtype, [159:156] zero
    logic [159:0] m_tdata;
    logic         cfg_we;
    logic         cfg_addr;
    logic [15:0]  cfg_data;
    int           mismatches;
    int           verdicts_due;

    int           sender_idle;
    int           receiver_stall;
    logic [7:0]   msg[$];

    bgp_message_validator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    bgp_result_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .verdicts_due (verdicts_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(0, 99) >= receiver_stall);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic void put(logic [7:0] b);
        msg.push_back(b);
    endfunction

    function automatic void put_random(int n);
        repeat (n) msg.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void frame_head(logic [15:0] len, logic [7:0] kind);
        msg.delete();
        repeat (16) msg.push_back(8'hFF);
        put(len[15:8]);
        put(len[7:0]);
        put(kind);
    endfunction

    function automatic void open_fields(logic [7:0] ver, logic [15:0] hold,
                                        logic [7:0] opt_len);
        put(ver);
        put_random(2);
        put(hold[15:8]);
        put(hold[7:0]);
        put_random(4);
        put(opt_len);
    endfunction

    function automatic logic [15:0] pick_hold();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 2));
            2:       return 16'd3;
            default: return 16'($urandom_range(3, 65535));
        endcase
    endfunction

    function automatic void fill_params(int area);
        int left;
        int vlen;
        left = area;
        while (left >= 2)
        begin
            vlen = (left - 2 <= 10) ? left - 2 : $urandom_range(0, 10);
            put(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                             : bmv_pkg::PARAM_CAPS);
            put(8'(vlen));
            put_random(vlen);
            left -= 2 + vlen;
        end
        put_random(left);
    endfunction

    function automatic void damage_message();
        int pos;
        case ($urandom_range(0, 3))
            0:
            begin
                pos = $urandom_range(0, msg.size() - 1);
                msg[pos] = msg[pos] ^ 8'(1 << $urandom_range(0, 7));
            end
            1:
            begin
                if (msg.size() > 1)
                    repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
            end
            2:
                put_random($urandom_range(1, 6));
            default:
            begin
                if (msg.size() > 18)
                    msg[16 + $urandom_range(0, 1)] = 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    function automatic void random_message();
        int         area;
        int         n;
        logic [7:0] rsub;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                area = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 24);
                frame_head(16'(29 + area), bmv_pkg::MSG_OPEN);
                open_fields(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                         : bmv_pkg::BGP_VERSION,
                            pick_hold(), 8'(area));
                fill_params(area);
            end
            3:
            begin
                n = $urandom_range(0, 40);
                frame_head(16'(23 + n), bmv_pkg::MSG_UPDATE);
                put_random(4 + n);
            end
            4:
            begin
                n = $urandom_range(0, 8);
                frame_head(16'(21 + n), bmv_pkg::MSG_NOTIF);
                put(8'($urandom_range(0, 8)));
                put(8'($urandom_range(0, 12)));
                put_random(n);
            end
            5:
                frame_head(16'd19, bmv_pkg::MSG_KEEPALIVE);
            6, 7:
            begin
                rsub = 8'($urandom_range(0, 3));
                n = (rsub == 8'd1 || rsub == 8'd2) ? 0 : $urandom_range(0, 6);
                frame_head(16'(23 + n), bmv_pkg::MSG_REFRESH);
                put_random(2);
                put(rsub);
                put_random(1 + n);
            end
            8:
            begin
                msg.delete();
                if ($urandom_range(0, 1) == 0)
                    repeat (16) msg.push_back(8'hFF);
                put_random($urandom_range(1, 30));
            end
            default:
            begin
                frame_head(16'($urandom_range(0, 60)), 8'($urandom_range(0, 7)));
                put_random($urandom_range(0, 50));
            end
        endcase
        if ($urandom_range(0, 4) == 0)
            damage_message();
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < sender_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_message();
        foreach (msg[i])
            push_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (verdicts_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [15:0] max_len, input logic upd);
        cfg_we   <= 1'b1;
        cfg_addr <= bmv_pkg::CFG_MAX_LEN;
        cfg_data <= max_len;
        @(posedge clk);
        cfg_addr <= bmv_pkg::CFG_UPDATE_EN;
        cfg_data <= {15'd0, upd};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_messages();
        frame_head(16'd29, bmv_pkg::MSG_OPEN);
        open_fields(bmv_pkg::BGP_VERSION, 16'd0, 8'd0);
        send_message();

        frame_head(16'd36, bmv_pkg::MSG_OPEN);
        open_fields(bmv_pkg::BGP_VERSION, 16'd3, 8'd7);
        put(bmv_pkg::PARAM_CAPS);
        put(8'd3);
        put_random(3);
        put(bmv_pkg::PARAM_CAPS);
        put(8'd0);
        send_message();

        frame_head(16'd29, bmv_pkg::MSG_OPEN);
        open_fields(bmv_pkg::BGP_VERSION + 8'd1, 16'hFFFF, 8'd0);
        send_message();

        for (int h = 1; h <= 2; h++)
        begin
            frame_head(16'd29, bmv_pkg::MSG_OPEN);
            open_fields(bmv_pkg::BGP_VERSION, 16'(h), 8'd0);
            send_message();
        end

        // optional parameter length beyond the room in the message
        frame_head(16'd29, bmv_pkg::MSG_OPEN);
        open_fields(bmv_pkg::BGP_VERSION, 16'd90, 8'd1);
        send_message();

        frame_head(16'd31, bmv_pkg::MSG_OPEN);
        open_fields(bmv_pkg::BGP_VERSION, 16'd90, 8'd2);
        put(bmv_pkg::PARAM_CAPS - 8'd1);
        put(8'd0);
        send_message();

        // parameter value overruns the area
        frame_head(16'd32, bmv_pkg::MSG_OPEN);
        open_fields(bmv_pkg::BGP_VERSION, 16'd90, 8'd3);
        put(bmv_pkg::PARAM_CAPS);
        put(8'd5);
        put_random(1);
        send_message();

        // area ends right after a parameter type
        frame_head(16'd30, bmv_pkg::MSG_OPEN);
        open_fields(bmv_pkg::BGP_VERSION, 16'd90, 8'd1);
        put(bmv_pkg::PARAM_CAPS);
        send_message();

        frame_head(16'd28, bmv_pkg::MSG_OPEN);
        open_fields(bmv_pkg::BGP_VERSION, 16'd90, 8'd0);
        send_message();

        frame_head(16'd23, bmv_pkg::MSG_UPDATE);
        put_random(4);
        send_message();

        frame_head(16'd22, bmv_pkg::MSG_UPDATE);
        put_random(3);
        send_message();

        for (int c = 0; c <= 8; c++)
        begin
            frame_head(16'(21 + c % 3), bmv_pkg::MSG_NOTIF);
            put(8'(c));
            put(8'($urandom_range(0, 12)));
            put_random(c % 3);
            send_message();
        end

        frame_head(16'd20, bmv_pkg::MSG_NOTIF);
        put_random(1);
        send_message();

        frame_head(16'd19, bmv_pkg::MSG_KEEPALIVE);
        send_message();

        frame_head(16'd20, bmv_pkg::MSG_KEEPALIVE);
        put_random(1);
        send_message();

        for (int s = 0; s <= 2; s++)
        begin
            frame_head(16'(23 + 4 * s), bmv_pkg::MSG_REFRESH);
            put_random(2);
            put(8'(s == 0 ? 1 : s == 1 ? 2 : 0));
            put_random(1 + 4 * s);
            send_message();
        end

        frame_head(16'd22, bmv_pkg::MSG_REFRESH);
        put_random(3);
        send_message();

        frame_head(16'd19, bmv_pkg::MSG_KEEPALIVE);
        msg[$urandom_range(0, 15)] = 8'hFF ^ 8'(1 << $urandom_range(0, 7));
        send_message();

        frame_head(16'd18, bmv_pkg::MSG_KEEPALIVE);
        send_message();

        frame_head(16'd4097, bmv_pkg::MSG_UPDATE);
        put_random(11);
        send_message();

        frame_head(16'd19, bmv_pkg::MSG_OPEN - 8'd1);
        send_message();
        frame_head(16'd19, bmv_pkg::MSG_REFRESH + 8'd1);
        send_message();
        frame_head(16'd19, 8'hFF);
        send_message();

        // buffers that end early, one inside the marker
        frame_head(16'd19, bmv_pkg::MSG_KEEPALIVE);
        repeat (9) void'(msg.pop_back());
        send_message();
        frame_head(16'd40, bmv_pkg::MSG_UPDATE);
        put_random(11);
        send_message();

        frame_head(16'd19, bmv_pkg::MSG_KEEPALIVE);
        put_random(5);
        send_message();

        msg.delete();
        put_random(1);
        send_message();
    endtask

    task automatic random_messages();
        int bytes_sent;
        int buffers;
        bytes_sent = 0;
        buffers    = 0;
        while (bytes_sent < 40 || buffers < 2)
        begin
            random_message();
            send_message();
            bytes_sent += msg.size();
            buffers++;
        end
    endtask

    initial
    begin
        sender_idle    = 0;
        receiver_stall = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tlast  <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_addr <= bmv_pkg::CFG_MAX_LEN;
        cfg_data <= 16'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_messages();

        drain();
        write_config(16'd19, 1'b1);
        sender_idle = 64;
        random_messages();

        drain();
        write_config(16'hFFFF, 1'b1);
        sender_idle    = 0;
        receiver_stall = 64;
        random_messages();

        drain();
        write_config(16'($urandom_range(23, 200)), 1'b0);
        sender_idle    = 6;
        receiver_stall = 6;
        frame_head(16'd23, bmv_pkg::MSG_UPDATE);
        put_random(4);
        send_message();
        random_messages();

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
